[hdl/quadtree_cell_code_unit_top_defines.svh]
// Assertion macros shared by the quadtree cell code unit modules.
`ifndef QUADTREE_CELL_CODE_UNIT_TOP_DEFINES_SVH
`define QUADTREE_CELL_CODE_UNIT_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define QC_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("qccu: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define QC_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("qccu: next-cycle check failed");

`endif

[hdl/qccu_pkg.sv]
// Types, codes and constants of the quadtree cell code unit.
package qccu_pkg;

    localparam int CODE_W  = 63;
    localparam int COORD_W = 31;
    localparam int LVL_W   = 5;
    localparam int FUNC_W  = 2;

    localparam logic [LVL_W-1:0]  MAX_LEVEL = LVL_W'(31);
    // last bit pair of a code; the lowest "pair" is bit 0 alone
    localparam logic [LVL_W-1:0]  LAST_PAIR = LVL_W'(CODE_W / 2);
    localparam logic [CODE_W-1:0] ROOT_CODE = CODE_W'(1) << (CODE_W - 1);

    localparam logic [FUNC_W-1:0] FUNC_ENCODE   = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_DECODE   = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_ANCESTOR = 2'd2;

    typedef struct packed {
        logic [FUNC_W-1:0]  func;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [LVL_W-1:0]   level;
        logic [CODE_W-1:0]  id_a;
        logic [CODE_W-1:0]  id_b;
    } t_in_item;

    typedef struct packed {
        logic [CODE_W-1:0]  cell_id;
        logic [COORD_W-1:0] out_x;
        logic [COORD_W-1:0] out_y;
        logic [LVL_W-1:0]   out_level;
    } t_out_item;

    typedef struct packed {
        logic idle;
        logic done;
    } t_eng_sts;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_RUN  = 3'b010,
        ST_FIN  = 3'b100
    } t_state;

endpackage

[hdl/qccu_engine.sv]
// Level-serial engine: encode, decode and common ancestor, one bit pair per cycle.
`include "quadtree_cell_code_unit_top_defines.svh"

module qccu_engine (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  qccu_pkg::t_in_item  i_item,
    input  logic                i_take,
    output qccu_pkg::t_eng_sts  o_sts,
    output qccu_pkg::t_out_item o_res
);
    import qccu_pkg::*;

    t_state              r_state, n_state;
    logic [FUNC_W-1:0]   r_func, n_func;
    logic [LVL_W-1:0]    r_lvl, n_lvl;
    logic [LVL_W-1:0]    r_cnt, n_cnt;
    logic                r_same, n_same;
    logic [COORD_W-1:0]  r_x, n_x;
    logic [COORD_W-1:0]  r_y, n_y;
    logic [CODE_W-1:0]   r_sa, n_sa;
    logic [CODE_W-1:0]   r_sb, n_sb;
    logic [CODE_W-1:0]   r_hold, n_hold;
    logic [CODE_W-1:0]   r_acc, n_acc;
    logic                pair_more;
    logic                pair_diff;
    logic                enc_busy;
    logic [CODE_W-1:0]   anc_code;

    // a pair is part of the decoded path while some bit below its upper bit is set
    assign pair_more = |r_sa[CODE_W-2:0];
    assign pair_diff = (r_sa[CODE_W-1:CODE_W-2] != r_sb[CODE_W-1:CODE_W-2]);
    assign enc_busy  = (r_state == ST_RUN) && (r_func == FUNC_ENCODE);

    always_comb begin
        n_state = r_state;
        n_func  = r_func;
        n_lvl   = r_lvl;
        n_cnt   = r_cnt;
        n_same  = r_same;
        n_x     = r_x;
        n_y     = r_y;
        n_sa    = r_sa;
        n_sb    = r_sb;
        n_hold  = r_hold;
        n_acc   = r_acc;
        case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    n_state = ST_RUN;
                    n_func  = i_item.func;
                    n_lvl   = (i_item.level > MAX_LEVEL) ? MAX_LEVEL : i_item.level;
                    n_cnt   = '0;
                    n_same  = 1'b0;
                    n_x     = (i_item.func == FUNC_ENCODE) ? i_item.x : '0;
                    n_y     = (i_item.func == FUNC_ENCODE) ? i_item.y : '0;
                    n_sa    = i_item.id_a;
                    n_sb    = i_item.id_b;
                    n_hold  = i_item.id_a;
                    // encode starts at the root marker and grows the code above it; ancestor sweeps a clear mask
                    n_acc   = (i_item.func == FUNC_ENCODE) ? ROOT_CODE : '1;
                end
            end
            ST_RUN: begin
                case (r_func)
                    FUNC_ENCODE: begin
                        if (r_cnt == r_lvl) begin
                            n_state = ST_FIN;
                        end else begin
                            // insert the next pair on top, push the marker down
                            n_acc = {r_x[0], r_y[0], r_acc[CODE_W-1:2]};
                            n_x   = r_x >> 1;
                            n_y   = r_y >> 1;
                            n_cnt = r_cnt + LVL_W'(1);
                        end
                    end
                    FUNC_DECODE: begin
                        if (!pair_more) begin
                            n_state = ST_FIN;
                        end else begin
                            n_x   = {r_x[COORD_W-2:0], r_sa[CODE_W-1]};
                            n_y   = {r_y[COORD_W-2:0], r_sa[CODE_W-2]};
                            n_sa  = {r_sa[CODE_W-3:0], 2'b00};
                            n_cnt = r_cnt + LVL_W'(1);
                        end
                    end
                    FUNC_ANCESTOR: begin
                        if (pair_diff) begin
                            n_state = ST_FIN;
                        end else if (r_cnt == LAST_PAIR) begin
                            n_state = ST_FIN;
                            n_same  = 1'b1;
                        end else begin
                            n_sa  = {r_sa[CODE_W-3:0], 2'b00};
                            n_sb  = {r_sb[CODE_W-3:0], 2'b00};
                            n_acc = {2'b00, r_acc[CODE_W-1:2]};
                            n_cnt = r_cnt + LVL_W'(1);
                        end
                    end
                    default: begin
                        n_state = ST_FIN;
                    end
                endcase
            end
            ST_FIN: begin
                if (i_take) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_func <= n_func;
        r_lvl  <= n_lvl;
        r_cnt  <= n_cnt;
        r_same <= n_same;
        r_x    <= n_x;
        r_y    <= n_y;
        r_sa   <= n_sa;
        r_sb   <= n_sb;
        r_hold <= n_hold;
        r_acc  <= n_acc;
    end

    // keep id_a above the first differing pair, marker at its upper bit (bit 1 for the lowest pair)
    always_comb begin
        if (r_same) begin
            anc_code = r_hold;
        end else if (r_cnt == LAST_PAIR) begin
            anc_code = {r_hold[CODE_W-1:2], 2'b10};
        end else begin
            anc_code = (r_hold & ~r_acc) | (r_acc & ~(r_acc >> 1));
        end
    end

    always_comb begin
        o_res = '0;
        case (r_func)
            FUNC_ENCODE: begin
                o_res.cell_id = r_acc;
            end
            FUNC_DECODE: begin
                o_res.out_x     = r_x;
                o_res.out_y     = r_y;
                o_res.out_level = r_cnt;
            end
            FUNC_ANCESTOR: begin
                o_res.cell_id = anc_code;
            end
            default: begin
                o_res = '0;
            end
        endcase
    end

    assign o_sts.idle = (r_state == ST_IDLE);
    assign o_sts.done = (r_state == ST_FIN);

    `QC_ASSERT_IMP(a_start_when_idle, i_clk, i_rst_n, i_start, r_state == ST_IDLE)
    `QC_ASSERT_IMP(a_enc_cnt_bound, i_clk, i_rst_n, enc_busy, r_cnt <= r_lvl)
    `QC_ASSERT_NXT(a_take_to_idle, i_clk, i_rst_n, o_sts.done && i_take, o_sts.idle)
    `QC_ASSERT_IMP(a_same_only_anc, i_clk, i_rst_n, o_sts.done && r_same, r_func == FUNC_ANCESTOR)

endmodule

[hdl/quadtree_cell_code_unit_top.sv]
// Top level of the quadtree cell code unit: input handshake, engine and output register.
// Encode and decode walk the levels one at a time; the output register then takes the result.
// Ancestor stops at the first differing pair, else at the last; unused codes finish directly.
// One item at a time: a new input beat is taken only once the engine is idle again.
// A finished result waits in the engine while the output register is still held.
// Reset (synchronous, active low) empties the engine and the output register; no clearing pass.
`include "quadtree_cell_code_unit_top_defines.svh"

module quadtree_cell_code_unit_top (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  qccu_pkg::t_in_item  i_item,
    output logic                o_valid,
    input  logic                i_ready,
    output qccu_pkg::t_out_item o_result
);
    import qccu_pkg::*;

    t_eng_sts   eng_sts;
    t_out_item  eng_res;
    logic       start;
    logic       take;
    logic       r_out_vld, n_out_vld;
    t_out_item  r_out;

    assign o_ready = eng_sts.idle;
    assign start   = i_valid && o_ready;
    // move the finished result into the output register once it is free
    assign take    = eng_sts.done && (!r_out_vld || i_ready);

    qccu_engine u_engine (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_item  (i_item),
        .i_take  (take),
        .o_sts   (eng_sts),
        .o_res   (eng_res)
    );

    always_comb begin
        if (take) begin
            n_out_vld = 1'b1;
        end else if (i_ready) begin
            n_out_vld = 1'b0;
        end else begin
            n_out_vld = r_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else begin
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_out <= eng_res;
        end
    end

    assign o_valid  = r_out_vld;
    assign o_result = r_out;

    `QC_ASSERT_IMP(a_ready_not_done, i_clk, i_rst_n, o_ready, !eng_sts.done)
    `QC_ASSERT_NXT(a_busy_after_beat, i_clk, i_rst_n, start, !o_ready)
    `QC_ASSERT_NXT(a_drain_empties, i_clk, i_rst_n, o_valid && i_ready && !take, !o_valid)

endmodule

[verif/tb_top.sv]
// Self-checking testbench for the quadtree cell code unit: encode, decode and common ancestor.
`timescale 1ns / 1ps

module tb_top;
    import qccu_pkg::*;

    localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
    localparam int RANDOM_ITEMS = 1750;
    localparam int DRAIN_CYCLES = 40;

    // Predicts one result per accepted item and checks results in order.
    class cell_code_board;
        t_out_item expected_codes[$];
        int        mismatches;

        function new();
            mismatches = 0;
        endfunction

        function t_out_item predict_cell_result(t_in_item it);
            t_out_item   res;
            logic [63:0] code;
            int          lvl;
            int          p;
            int          k;
            int          m;
            res = '0;
            case (it.func)
                FUNC_ENCODE: begin
                    lvl = it.level;
                    if (lvl > MAX_LEVEL)
                        lvl = MAX_LEVEL;
                    code = '0;
                    // x bit then y bit per level, most significant level first
                    for (k = 0; k < lvl; k++) begin
                        code[62 - 2 * k] = it.x[lvl - 1 - k];
                        code[61 - 2 * k] = it.y[lvl - 1 - k];
                    end
                    code[62 - 2 * lvl] = 1'b1;
                    res.cell_id = code[CODE_W-1:0];
                end
                FUNC_DECODE: begin
                    if (it.id_a != '0) begin
                        p = 0;
                        while (!it.id_a[p])
                            p++;
                        // an odd end marker is read as the last y bit
                        lvl = (63 - p) / 2;
                        for (k = 0; k < lvl; k++) begin
                            res.out_x = {res.out_x[COORD_W-2:0], it.id_a[62 - 2 * k]};
                            res.out_y = {res.out_y[COORD_W-2:0], it.id_a[61 - 2 * k]};
                        end
                        res.out_level = LVL_W'(lvl);
                    end
                end
                FUNC_ANCESTOR: begin
                    if (it.id_a == it.id_b) begin
                        res.cell_id = it.id_a;
                    end else begin
                        k = 0;
                        while (k < LAST_PAIR && it.id_a[62 - 2 * k] == it.id_b[62 - 2 * k]
                               && it.id_a[61 - 2 * k] == it.id_b[61 - 2 * k])
                            k++;
                        // the lowest pair is bit 0 alone: marker lands on bit 1
                        m = (k < LAST_PAIR) ? 62 - 2 * k : 1;
                        code = {1'b0, it.id_a};
                        code = (code & ~((64'd2 << m) - 64'd1)) | (64'd1 << m);
                        res.cell_id = code[CODE_W-1:0];
                    end
                end
                default: res = '0;
            endcase
            return res;
        endfunction

        function void note_accepted(t_in_item it);
            expected_codes.push_back(predict_cell_result(it));
        endfunction

        function void check_result(t_out_item got);
            t_out_item exp;
            if (expected_codes.size() == 0) begin
                $display("%0t: result with nothing pending: id=%h x=%h y=%h lvl=%0d",
                         $time, got.cell_id, got.out_x, got.out_y, got.out_level);
                mismatches++;
                return;
            end
            exp = expected_codes.pop_front();
            if (got.cell_id !== exp.cell_id) begin
                $display("%0t: cell_id mismatch: expected %h, actual %h",
                         $time, exp.cell_id, got.cell_id);
                mismatches++;
            end
            if (got.out_x !== exp.out_x) begin
                $display("%0t: out_x mismatch: expected %h, actual %h",
                         $time, exp.out_x, got.out_x);
                mismatches++;
            end
            if (got.out_y !== exp.out_y) begin
                $display("%0t: out_y mismatch: expected %h, actual %h",
                         $time, exp.out_y, got.out_y);
                mismatches++;
            end
            if (got.out_level !== exp.out_level) begin
                $display("%0t: out_level mismatch: expected %0d, actual %0d",
                         $time, exp.out_level, got.out_level);
                mismatches++;
            end
        endfunction
    endclass

    logic      i_clk;
    logic      i_rst_n;
    logic      i_valid;
    logic      o_ready;
    t_in_item  i_item;
    logic      o_valid;
    logic      i_ready;
    t_out_item o_result;

    cell_code_board board;

    quadtree_cell_code_unit_top dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .i_item   (i_item),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .o_result (o_result)
    );

    always begin
        i_clk = 1'b0;
        #1;
        i_clk = 1'b1;
        #1;
    end

    function automatic logic [CODE_W-1:0] rand_code();
        return CODE_W'({$urandom, $urandom});
    endfunction

    // Random well-formed code at the given level.
    function automatic logic [CODE_W-1:0] make_cell(int lvl);
        logic [CODE_W-1:0] c;
        int                m;
        c = rand_code();
        m = 62 - 2 * lvl;
        c = c & ~((CODE_W'(2) << m) - CODE_W'(1));
        c[m] = 1'b1;
        return c;
    endfunction

    task automatic send_item(input t_in_item it);
        @(negedge i_clk);
        i_valid <= 1'b1;
        i_item  <= it;
        do
            @(posedge i_clk);
        while (!o_ready);
        board.note_accepted(it);
    endtask

    task automatic send_op(input logic [FUNC_W-1:0] func, input logic [COORD_W-1:0] x,
                           input logic [COORD_W-1:0] y, input logic [LVL_W-1:0] level,
                           input logic [CODE_W-1:0] a, input logic [CODE_W-1:0] b);
        t_in_item it;
        it.func  = func;
        it.x     = x;
        it.y     = y;
        it.level = level;
        it.id_a  = a;
        it.id_b  = b;
        send_item(it);
    endtask

    task automatic hold_input(input int cycles);
        repeat (cycles) begin
            @(negedge i_clk);
            i_valid <= 1'b0;
        end
    endtask

    function automatic t_in_item random_item();
        t_in_item          it;
        logic [CODE_W-1:0] keep;
        int                sel;
        it.func  = FUNC_W'($urandom);
        it.x     = COORD_W'($urandom);
        it.y     = COORD_W'($urandom);
        it.level = LVL_W'($urandom_range(0, 31));
        it.id_a  = rand_code();
        it.id_b  = rand_code();
        sel = $urandom_range(0, 99);
        if (sel < 30) begin
            it.func = FUNC_ENCODE;
        end else if (sel < 50) begin
            it.func = FUNC_DECODE;
            it.id_a = make_cell($urandom_range(0, 31));
        end else if (sel < 60) begin
            // move the lowest set bit around, odd positions included
            it.func = FUNC_DECODE;
            it.id_a = rand_code() << $urandom_range(0, 62);
        end else if (sel < 85) begin
            // two cells sharing a random-length prefix
            it.func = FUNC_ANCESTOR;
            it.id_a = make_cell($urandom_range(0, 31));
            it.id_b = make_cell($urandom_range(0, 31));
            keep    = ~((CODE_W'(1) << $urandom_range(0, 62)) - CODE_W'(1));
            it.id_b = (it.id_a & keep) | (it.id_b & ~keep);
        end else if (sel < 90) begin
            it.func = FUNC_ANCESTOR;
            it.id_b = it.id_a;
        end else if (sel < 95) begin
            it.func = FUNC_ANCESTOR;
        end else begin
            it.func = FUNC_UNUSED;
        end
        return it;
    endfunction

    // Give up after a generous fixed time.
    initial begin
        #2000000;
        $display("Verification failed");
        $finish;
    end

    // Receiver: own stall pattern, plus long hold-offs to back the block up.
    initial begin
        int taken;
        int hold_left;
        int cyc;
        int mode;
        int period;
        int duty;
        taken     = 0;
        hold_left = 0;
        cyc       = 0;
        mode      = 0;
        period    = 4;
        duty      = 1;
        i_ready   = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (cyc % 96 == 0) begin
                mode   = $urandom_range(0, 2);
                period = $urandom_range(2, 9);
                duty   = $urandom_range(1, period - 1);
            end
            cyc++;
            if (hold_left > 0) begin
                i_ready <= 1'b0;
                hold_left--;
            end else if (mode == 0) begin
                i_ready <= 1'b1;
            end else if (mode == 1) begin
                i_ready <= (cyc % period) >= duty;
            end else begin
                i_ready <= ($urandom_range(0, 2) != 0);
            end
            @(posedge i_clk);
            if (o_valid && i_ready) begin
                board.check_result(o_result);
                taken++;
                if (taken == 400 || taken == 1300)
                    hold_left = 150;
            end
        end
    end

    // Sender: directed items, then random bursts with random gaps.
    initial begin
        int sent;
        int burst;
        board   = new();
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_item  = '0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        send_op(FUNC_ENCODE, '1, '1, 5'd0, '0, '0);
        send_op(FUNC_ENCODE, '1, '0, 5'd1, '0, '0);
        send_op(FUNC_ENCODE, '0, '1, 5'd1, '0, '0);
        send_op(FUNC_ENCODE, '1, '1, MAX_LEVEL, '1, '1);
        send_op(FUNC_ENCODE, '0, '1, MAX_LEVEL, '0, '0);
        send_op(FUNC_ENCODE, 31'h5555_5555, 31'h2AAA_AAAA, 5'd16, '0, '0);
        send_op(FUNC_ENCODE, '1, '0, 5'd30, '0, '0);
        send_op(FUNC_DECODE, '1, '1, '1, '0, '1);
        send_op(FUNC_DECODE, '0, '0, '0, ROOT_CODE, '0);
        send_op(FUNC_DECODE, '0, '0, '0, '1, '0);
        send_op(FUNC_DECODE, '0, '0, '0, CODE_W'(1), '0);
        send_op(FUNC_DECODE, '0, '0, '0, CODE_W'(2), '0);
        send_op(FUNC_DECODE, '0, '0, '0, ROOT_CODE >> 1, '0);
        send_op(FUNC_DECODE, '0, '0, '0, 63'h2AAA_AAAA_AAAA_AAA8, '0);
        send_op(FUNC_ANCESTOR, '0, '0, '0, '1, '1);
        send_op(FUNC_ANCESTOR, '0, '0, '0, '0, '0);
        send_op(FUNC_ANCESTOR, '0, '0, '0, ROOT_CODE, '0);
        send_op(FUNC_ANCESTOR, '0, '0, '0, '1, '0);
        send_op(FUNC_ANCESTOR, '0, '0, '0, '1, 63'h7FFF_FFFF_FFFF_FFFE);
        send_op(FUNC_ANCESTOR, '0, '0, '0, 63'h1234_5678_9ABC_DEF7, 63'h1234_5678_9ABC_DEF5);
        send_op(FUNC_ANCESTOR, '0, '0, '0, 63'h5000_0000_0000_0000, 63'h7000_0000_0000_0000);
        send_op(FUNC_UNUSED, '1, '1, '1, '1, '1);
        send_op(FUNC_UNUSED, '0, '0, '0, '0, '0);

        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            burst = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 12);
            repeat (burst) begin
                send_item(random_item());
                sent++;
            end
            if ($urandom_range(0, 3) != 0)
                hold_input($urandom_range(1, 8));
        end
        @(negedge i_clk);
        i_valid <= 1'b0;

        while (board.expected_codes.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (board.mismatches == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
